[rtl/pvf_pkg.sv]
// ----------------------------------------------------------------------------
// pvf_pkg
// Shared constants, codes and controller/datapath bundles of the print verb
// formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package pvf_pkg;

  // Default bound on the text length (saturating counter cap follows from it)
  localparam int MAX_TEXT_DEFAULT = 1024;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int ARG_W  = 32;
  localparam int LEN_W  = 10;

  // Decimal digits of a 32-bit value, hex digits of a 32-bit value
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int DIG_W      = 4 * DEC_DIGITS;
  localparam int NDIG_W     = 4;
  localparam int BIT_CNT_W  = 5;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_L     = 8'h6c;
  localparam logic [CHAR_W-1:0] CHAR_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CHAR_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_S     = 8'h73;

  // Action classes of a format byte
  localparam logic [2:0] ACT_END  = 3'd0;
  localparam logic [2:0] ACT_OPEN = 3'd1;
  localparam logic [2:0] ACT_SKIP = 3'd2;
  localparam logic [2:0] ACT_COPY = 3'd3;
  localparam logic [2:0] ACT_CHR  = 3'd4;
  localparam logic [2:0] ACT_DEC  = 3'd5;
  localparam logic [2:0] ACT_UNS  = 3'd6;
  localparam logic [2:0] ACT_HEX  = 3'd7;

  // Output byte sources
  localparam logic [2:0] PUT_CHAR  = 3'd0;
  localparam logic [2:0] PUT_ARGB  = 3'd1;
  localparam logic [2:0] PUT_MINUS = 3'd2;
  localparam logic [2:0] PUT_DIGIT = 3'd3;
  localparam logic [2:0] PUT_END   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;        // capture the input transaction
    logic       commit;      // update the verb flag for the captured byte
    logic       put;         // write one result into the output register
    logic [2:0] put_sel;     // source of the result byte
    logic       put_last;    // result is the last one for this byte
    logic       conv_start;  // load the magnitude for decimal conversion
    logic       hex_load;    // load hex nibbles straight into the digit register
    logic       conv_step;   // one double-dabble step
    logic       dig_shift;   // drop the top digit
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] act;         // class of the captured byte
    logic       neg;         // argument sign bit
    logic       conv_last;   // current conversion step is the final one
    logic       top_zero;    // top digit is zero
    logic       ndig_one;    // one digit left
    logic       can_put;     // output register can take a result
  } stat_t;

  // Lowercase hex digit character
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/pvf_in_if.sv]
// ----------------------------------------------------------------------------
// pvf_in_if
// Format byte channel: one format byte with its argument word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvf_in_if;
  logic                           valid;
  logic                           ready;
  logic [pvf_pkg::CHAR_W-1:0]     fmt_char;
  logic [pvf_pkg::ARG_W-1:0]      argument;

  modport source (output valid, output fmt_char, output argument, input ready);
  modport sink   (input valid, input fmt_char, input argument, output ready);
endinterface

`default_nettype wire

[rtl/pvf_out_if.sv]
// ----------------------------------------------------------------------------
// pvf_out_if
// Output text channel: one text byte with end marker, length and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvf_out_if;
  logic                           valid;
  logic                           ready;
  logic [pvf_pkg::CHAR_W-1:0]     out_char;
  logic                           end_of_text;
  logic [pvf_pkg::LEN_W-1:0]      text_length;
  logic                           last;

  modport source (output valid, output out_char, output end_of_text,
                  output text_length, output last, input ready);
  modport sink   (input valid, input out_char, input end_of_text,
                  input text_length, input last, output ready);
endinterface

`default_nettype wire

[rtl/pvf_datapath.sv]
// ----------------------------------------------------------------------------
// pvf_datapath
// Byte capture and classification, verb flag, length counter, double-dabble
// decimal converter, digit shift register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvf_datapath #(
  parameter int MaxText = pvf_pkg::MAX_TEXT_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [pvf_pkg::CHAR_W-1:0] fmt_char,
  input  wire logic [pvf_pkg::ARG_W-1:0]  argument,
  input  wire pvf_pkg::cmd_t cmd,
  output pvf_pkg::stat_t     stat,
  pvf_out_if.source          text_out
);

  localparam int CountCap = ((MaxText - 1) < 1023) ? (MaxText - 1) : 1023;
  localparam int DigW     = pvf_pkg::DIG_W;

  logic [pvf_pkg::CHAR_W-1:0] ch;
  logic [pvf_pkg::ARG_W-1:0]  arg;
  logic                       in_verb;
  logic [pvf_pkg::LEN_W-1:0]  count;
  logic [DigW-1:0]            dig;
  logic [pvf_pkg::ARG_W-1:0]  bin;
  logic [pvf_pkg::BIT_CNT_W-1:0] bitcnt;
  logic [pvf_pkg::NDIG_W-1:0] ndig;
  logic                       out_valid;
  logic [pvf_pkg::CHAR_W-1:0] out_char;
  logic                       out_end;
  logic [pvf_pkg::LEN_W-1:0]  out_len;
  logic                       out_last;

  logic [2:0]                 act;
  logic [DigW-1:0]            dig_adj;
  logic [pvf_pkg::CHAR_W-1:0] put_char;
  logic                       can_put;

  // Classify the captured byte
  always_comb begin
    if (ch == pvf_pkg::CHAR_NUL) begin
      act = pvf_pkg::ACT_END;
    end else if (!in_verb) begin
      act = (ch == pvf_pkg::CHAR_PCT) ? pvf_pkg::ACT_OPEN : pvf_pkg::ACT_COPY;
    end else if (ch == pvf_pkg::CHAR_L || ch == pvf_pkg::CHAR_S) begin
      act = pvf_pkg::ACT_SKIP;
    end else if (ch == pvf_pkg::CHAR_D) begin
      act = pvf_pkg::ACT_DEC;
    end else if (ch == pvf_pkg::CHAR_U) begin
      act = pvf_pkg::ACT_UNS;
    end else if (ch == pvf_pkg::CHAR_X) begin
      act = pvf_pkg::ACT_HEX;
    end else if (ch == pvf_pkg::CHAR_C) begin
      act = pvf_pkg::ACT_CHR;
    end else begin
      act = pvf_pkg::ACT_COPY;
    end
  end

  // Add three to every BCD digit of five or more
  always_comb begin
    for (int i = 0; i < pvf_pkg::DEC_DIGITS; i++) begin
      dig_adj[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3
                                                   : dig[4*i +: 4];
    end
  end

  // Pick the result byte
  always_comb begin
    unique case (cmd.put_sel)
      pvf_pkg::PUT_CHAR:  put_char = ch;
      pvf_pkg::PUT_ARGB:  put_char = arg[pvf_pkg::CHAR_W-1:0];
      pvf_pkg::PUT_MINUS: put_char = pvf_pkg::CHAR_MINUS;
      pvf_pkg::PUT_DIGIT: put_char = pvf_pkg::hex_char(dig[DigW-1 -: 4]);
      default:            put_char = pvf_pkg::CHAR_NUL;
    endcase
  end

  assign can_put = !out_valid || text_out.ready;

  // Capture the transaction and update the verb flag
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch  <= fmt_char;
      arg <= argument;
    end
    if (rst) begin
      in_verb <= 1'b0;
    end else if (cmd.commit) begin
      in_verb <= (act == pvf_pkg::ACT_OPEN) || (in_verb && ch == pvf_pkg::CHAR_L);
    end
  end

  // Count emitted bytes, saturating; clear at end of text
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.put) begin
      if (cmd.put_sel == pvf_pkg::PUT_END) begin
        count <= '0;
      end else if (count < pvf_pkg::LEN_W'(CountCap)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Converter and digit register
  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      bin    <= (act == pvf_pkg::ACT_DEC && arg[pvf_pkg::ARG_W-1]) ? (~arg + 1'b1) : arg;
      dig    <= '0;
      bitcnt <= '0;
      ndig   <= pvf_pkg::NDIG_W'(pvf_pkg::DEC_DIGITS);
    end else if (cmd.hex_load) begin
      dig  <= {arg, (DigW - pvf_pkg::ARG_W)'(0)};
      ndig <= pvf_pkg::NDIG_W'(pvf_pkg::HEX_DIGITS);
    end else if (cmd.conv_step) begin
      dig    <= {dig_adj[DigW-2:0], bin[pvf_pkg::ARG_W-1]};
      bin    <= {bin[pvf_pkg::ARG_W-2:0], 1'b0};
      bitcnt <= bitcnt + 1'b1;
    end else if (cmd.dig_shift) begin
      dig  <= {dig[DigW-5:0], 4'h0};
      ndig <= ndig - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (text_out.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.put) begin
      out_char <= put_char;
      out_end  <= (cmd.put_sel == pvf_pkg::PUT_END);
      out_len  <= (cmd.put_sel == pvf_pkg::PUT_END) ? count : '0;
      out_last <= cmd.put_last;
    end
  end

  assign text_out.valid       = out_valid;
  assign text_out.out_char    = out_char;
  assign text_out.end_of_text = out_end;
  assign text_out.text_length = out_len;
  assign text_out.last        = out_last;

  assign stat.act       = act;
  assign stat.neg       = arg[pvf_pkg::ARG_W-1];
  assign stat.conv_last = (bitcnt == '1);
  assign stat.top_zero  = (dig[DigW-1 -: 4] == 4'h0);
  assign stat.ndig_one  = (ndig == pvf_pkg::NDIG_W'(1));
  assign stat.can_put   = can_put;

endmodule

`default_nettype wire

[rtl/pvf_ctrl.sv]
// ----------------------------------------------------------------------------
// pvf_ctrl
// Sequencer of the formatter: accepts one byte, dispatches on its class,
// runs the decimal conversion, skips leading zeros and emits digits.
// ----------------------------------------------------------------------------
`default_nettype none

module pvf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pvf_pkg::stat_t stat,
  output pvf_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CONV   = 3'd2;
  localparam logic [2:0] S_SKIP   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.put_sel = pvf_pkg::PUT_CHAR;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          pvf_pkg::ACT_END, pvf_pkg::ACT_COPY, pvf_pkg::ACT_CHR: begin
            if (stat.can_put) begin
              cmd.put      = 1'b1;
              cmd.put_last = 1'b1;
              cmd.commit   = 1'b1;
              cmd.put_sel  = (stat.act == pvf_pkg::ACT_END) ? pvf_pkg::PUT_END :
                             (stat.act == pvf_pkg::ACT_CHR) ? pvf_pkg::PUT_ARGB :
                                                              pvf_pkg::PUT_CHAR;
              state_next   = S_IDLE;
            end
          end
          pvf_pkg::ACT_OPEN, pvf_pkg::ACT_SKIP: begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
          pvf_pkg::ACT_DEC: begin
            if (!stat.neg || stat.can_put) begin
              cmd.put        = stat.neg;
              cmd.put_sel    = pvf_pkg::PUT_MINUS;
              cmd.commit     = 1'b1;
              cmd.conv_start = 1'b1;
              state_next     = S_CONV;
            end
          end
          pvf_pkg::ACT_UNS: begin
            cmd.commit     = 1'b1;
            cmd.conv_start = 1'b1;
            state_next     = S_CONV;
          end
          default: begin
            cmd.commit   = 1'b1;
            cmd.hex_load = 1'b1;
            state_next   = S_SKIP;
          end
        endcase
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (stat.top_zero && !stat.ndig_one) begin
          cmd.dig_shift = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.can_put) begin
          cmd.put       = 1'b1;
          cmd.put_sel   = pvf_pkg::PUT_DIGIT;
          cmd.put_last  = stat.ndig_one;
          cmd.dig_shift = 1'b1;
          if (stat.ndig_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/print_verb_formatter_unit.sv]
// ----------------------------------------------------------------------------
// print_verb_formatter_unit
// Printf-style integer formatter: format bytes in, text bytes out, with
// decimal, unsigned, hex and character verbs.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         handshake
//  fmt_in    in   fmt_char[7:0], argument[31:0]                   valid/ready
//  text_out  out  out_char[7:0], end_of_text, text_length[9:0],   valid/ready
//                 last
//
//  One format byte is taken at a time. A plain byte, %c or end of text gives
//  one result; %, l and s give nothing. %x loads the hex nibbles, skips leading
//  zeros and emits the digits. %d and %u run the bit-serial double-dabble
//  converter (32 steps), skip leading zeros and emit the digits, the minus sign
//  going out in the decode cycle.
//  Reset (rst, synchronous) clears the verb flag, the length counter and the
//  output register. A stalled output holds the sequencer; no input is taken
//  until all results of the current byte have entered the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module print_verb_formatter_unit #(
  parameter int MaxText = pvf_pkg::MAX_TEXT_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pvf_in_if.sink     fmt_in,
  pvf_out_if.source  text_out
);

  pvf_pkg::cmd_t  cmd;
  pvf_pkg::stat_t stat;
  logic           in_ready;

  assign fmt_in.ready = in_ready;

  pvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fmt_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pvf_datapath #(
    .MaxText (MaxText)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .fmt_char (fmt_in.fmt_char),
    .argument (fmt_in.argument),
    .cmd      (cmd),
    .stat     (stat),
    .text_out (text_out)
  );

endmodule

`default_nettype wire
